// ===== src/utf8_codepoint_decoder_unit_assert.svh =====
// Assertion macros used by the UTF-8 decoder top level.
`ifndef UTF8_CODEPOINT_DECODER_UNIT_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTF8D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/utf8d_pkg.sv =====
// Types, constants and decode helpers of the UTF-8 code point decoder.
package utf8d_pkg;

  localparam int OFFSET_BITS    = 32;
  localparam int MAX_RESULTS    = 3;
  localparam int RES_COUNT_BITS = $clog2(MAX_RESULTS + 1);
  localparam int PENDING_DEPTH  = 3;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [31:0] byte_offset;
    logic        replaced;
    logic        text_valid;
    logic        run_last;
    logic        text_done;
  } result_t;

  typedef struct packed {
    logic [1:0] pending_count;
    offset_t    lead_offset;
    offset_t    byte_counter;
    logic       valid_flag;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    pending_count: 2'd0,
    lead_offset:   '0,
    byte_counter:  '0,
    valid_flag:    1'b1
  };

  // Sequence length from the lead byte; zero marks a bad lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Builds a code point from up to four bytes, lead byte in the low byte.
  function automatic logic [20:0] assemble(input logic [31:0] w, input logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd2:    cp = {10'd0, w[4:0], w[13:8]};
      3'd3:    cp = {5'd0, w[3:0], w[13:8], w[21:16]};
      3'd4:    cp = {w[2:0], w[13:8], w[21:16], w[29:24]};
      default: cp = {13'd0, w[7:0]};
    endcase
    return cp;
  endfunction

endpackage

// ===== src/utf8_codepoint_decoder_unit.sv =====
// Top level of the UTF-8 decoder: input handshake, sequence state and result buffer.
// Latency: a word's first result is offered on the cycle after the word is accepted.
// Throughput: one word per cycle while cp_ready is high; a final word that yields k results
// holds the input while the result buffer drains one result per cycle that cp_ready is high.
// Reset (rst, synchronous, active high) empties the result buffer and clears the
// sequence state; the buffered sequence bytes themselves are not cleared.
module utf8_codepoint_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output logic        cp_valid,
  input  logic        cp_ready,
  output logic [20:0] code_point,
  output logic [31:0] byte_offset,
  output logic        replaced,
  output logic        text_valid,
  output logic        run_last,
  output logic        text_done
);
  import utf8d_pkg::*;

  // Sequence state: count of buffered bytes, lead offset, running offset and the
  // sticky validity flag. Buffered bytes are read only below the count, so they
  // need no reset.
  dec_state_t                     st;
  dec_state_t                     st_next;
  logic [PENDING_DEPTH-1:0][7:0]  pending_bytes;

  // Result buffer: up to three results of one word, head at entry zero. The
  // count of results still waiting decides when the next word may enter.
  result_t [MAX_RESULTS-1:0]      res_q;
  logic [RES_COUNT_BITS-1:0]      rem;

  result_t [MAX_RESULTS-1:0]      results;
  logic [RES_COUNT_BITS-1:0]      result_count;
  logic                           store_en;
  logic                           accept;
  logic                           pop;

  utf8d_decode u_decode (
    .data_byte     (data_byte),
    .end_of_text   (end_of_text),
    .pending_bytes (pending_bytes),
    .state         (st),
    .state_next    (st_next),
    .store_en      (store_en),
    .results       (results),
    .result_count  (result_count)
  );

  // A new word enters when the buffer is empty, or when its last waiting result
  // leaves in this same cycle, so single-result words stream at full rate.
  assign cp_valid   = (rem != '0);
  assign pop        = cp_valid && cp_ready;
  assign byte_ready = (rem == '0) || ((rem == RES_COUNT_BITS'(1)) && cp_ready);
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Only the entry at the current count is written when a short sequence grows.
  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      pending_bytes[st.pending_count] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (accept && (result_count != '0)) begin
      rem <= result_count;
    end else if (pop) begin
      rem <= rem - RES_COUNT_BITS'(1);
    end
  end

  // Results load as a group and then shift toward the head as each one is taken.
  always_ff @(posedge clk) begin
    if (accept && (result_count != '0)) begin
      res_q <= results;
    end else if (pop) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
        res_q[k] <= res_q[k+1];
      end
    end
  end

  assign code_point  = res_q[0].code_point;
  assign byte_offset = res_q[0].byte_offset;
  assign replaced    = res_q[0].replaced;
  assign text_valid  = res_q[0].text_valid;
  assign run_last    = res_q[0].run_last;
  assign text_done   = res_q[0].text_done;

  `include "utf8_codepoint_decoder_unit_assert.svh"

  // A result that is not the last of its word always has another one behind it.
  `UTF8D_ASSERT_IMP(a_more_behind, clk, rst, cp_valid && !run_last, rem > RES_COUNT_BITS'(1), "non-last result with nothing behind it")
  // A replacement always drops the running validity of the text.
  `UTF8D_ASSERT_IMP(a_rep_invalid, clk, rst, cp_valid && replaced, !text_valid, "replacement shown with text still valid")
  // Pending count, byte counter and validity flag are back at their reset values after the final word.
  `UTF8D_ASSERT_NXT(a_eot_clear, clk, rst, accept && end_of_text, (st.pending_count == 2'd0) && (st.byte_counter == '0) && st.valid_flag, "state not cleared after end of text")

endmodule

// ===== src/utf8d_decode.sv =====
// Single-pass decode of one input word against the buffered sequence bytes.
module utf8d_decode (
  input  logic [7:0]                                      data_byte,
  input  logic                                            end_of_text,
  input  logic [utf8d_pkg::PENDING_DEPTH-1:0][7:0]        pending_bytes,
  input  utf8d_pkg::dec_state_t                           state,
  output utf8d_pkg::dec_state_t                           state_next,
  output logic                                            store_en,
  output utf8d_pkg::result_t [utf8d_pkg::MAX_RESULTS-1:0] results,
  output logic [utf8d_pkg::RES_COUNT_BITS-1:0]            result_count
);
  import utf8d_pkg::*;

  logic [1:0]  cnt;
  logic [2:0]  n;
  logic [3:0][7:0] buf_b;
  offset_t     base;
  logic [2:0]  pos   [MAX_RESULTS+1];
  logic        act   [MAX_RESULTS];
  logic        rep   [MAX_RESULTS];
  logic [31:0] win   [MAX_RESULTS];
  logic [2:0]  len   [MAX_RESULTS];
  logic        store;
  logic        tv;
  offset_t     ofs;

  assign cnt = state.pending_count;
  assign n   = {1'b0, cnt} + 3'd1;

  always_comb begin
    buf_b[0] = (cnt == 2'd0) ? data_byte : pending_bytes[0];
    buf_b[1] = (cnt == 2'd1) ? data_byte : ((cnt > 2'd1) ? pending_bytes[1] : 8'h00);
    buf_b[2] = (cnt == 2'd2) ? data_byte : ((cnt > 2'd2) ? pending_bytes[2] : 8'h00);
    buf_b[3] = (cnt == 2'd3) ? data_byte : 8'h00;
  end

  assign base = (cnt == 2'd0) ? state.byte_counter : state.lead_offset;

  // Walk over at most three sequence starts within the buffered bytes.
  always_comb begin
    pos[0] = 3'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      win[k] = 32'(buf_b) >> {pos[k], 3'b000};
      len[k] = seq_len(win[k][7:0]);
      act[k] = (pos[k] < n);
      rep[k] = (len[k] == 3'd0) || (({1'b0, pos[k]} + {1'b0, len[k]}) > {1'b0, n});
      pos[k+1] = rep[k] ? (pos[k] + 3'd1) : (pos[k] + len[k]);
    end
  end

  // A non-final word whose sequence is still short is only buffered.
  assign store    = !end_of_text && (len[0] != 3'd0) && ({1'b0, len[0]} > {1'b0, n});
  assign store_en = store;

  always_comb begin
    if (end_of_text) begin
      result_count = RES_COUNT_BITS'({1'b0, act[0]} + {1'b0, act[1]} + {1'b0, act[2]});
    end else if (store) begin
      result_count = '0;
    end else begin
      result_count = RES_COUNT_BITS'(1);
    end
  end

  always_comb begin
    tv = state.valid_flag;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      tv  = tv & !rep[k];
      ofs = base + OFFSET_BITS'(pos[k]);
      results[k].code_point  = rep[k] ? REPLACEMENT_CP : assemble(win[k], len[k]);
      results[k].byte_offset = ofs[31:0];
      results[k].replaced    = rep[k];
      results[k].text_valid  = tv;
      results[k].run_last    = (RES_COUNT_BITS'(k + 1) == result_count);
      results[k].text_done   = end_of_text && (RES_COUNT_BITS'(k + 1) == result_count);
    end
  end

  always_comb begin
    state_next = state;
    if (end_of_text) begin
      state_next = STATE_RESET;
    end else if (store) begin
      state_next.pending_count = n[1:0];
      state_next.lead_offset   = base;
      state_next.byte_counter  = state.byte_counter + OFFSET_BITS'(1);
    end else begin
      state_next.pending_count = 2'd0;
      state_next.byte_counter  = state.byte_counter + OFFSET_BITS'(1);
      state_next.valid_flag    = state.valid_flag & !rep[0];
    end
  end

endmodule
